@@ rtl/core/glyph_row_text_renderer_macros.svh @@
// ----------------------------------------------------------------------------
// Glyph row text renderer assertion macros
// Shorthand for clocked implication checks, disabled during reset.
// ----------------------------------------------------------------------------
`ifndef GLYPH_ROW_TEXT_RENDERER_MACROS_SVH
`define GLYPH_ROW_TEXT_RENDERER_MACROS_SVH

// same-cycle implication
`define GRTR_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("grtr same-cycle check failed");

// next-cycle implication
`define GRTR_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("grtr next-cycle check failed");

`endif

@@ rtl/core/grtr_pkg.sv @@
// ----------------------------------------------------------------------------
// grtr_pkg
// Shared widths, glyph kinds, register indexes and geometry helpers.
// ----------------------------------------------------------------------------
package grtr_pkg;

   localparam int COORD_W    = 9;
   localparam int COLOR_W    = 16;
   localparam int ROW_BITS_W = 32;
   localparam int KIND_W     = 2;
   localparam int RIG_W      = 5;
   localparam int CNT_W      = 5;
   localparam int DIM_W      = 6;
   localparam int LIMIT_W    = 10;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam int SCREEN_SIZE = 240;

   localparam logic [CSR_IDX_W-1:0] CSR_FONT_COLOR = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BACK_COLOR = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_OPAQUE     = 2'd2;

   localparam logic [COLOR_W-1:0] FONT_COLOR_RST = 16'hFFFF;
   localparam logic [COLOR_W-1:0] BACK_COLOR_RST = 16'h0000;
   localparam logic               OPAQUE_RST     = 1'b1;

   typedef enum logic [KIND_W-1:0] {
      KIND_ASCII_8X16  = 2'd0,
      KIND_ASCII_16X32 = 2'd1,
      KIND_CJK_16X16   = 2'd2,
      KIND_CJK_32X32   = 2'd3
   } kind_type;

   typedef enum logic {
      ST_IDLE,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic pix_set;
      logic pix_emit;
      logic row_done;
   } ser_status_type;

   function automatic logic [DIM_W-1:0] kind_width(input kind_type kind);
      logic [DIM_W-1:0] w;
      unique case (kind)
         KIND_ASCII_8X16:  w = 6'd8;
         KIND_ASCII_16X32: w = 6'd16;
         KIND_CJK_16X16:   w = 6'd16;
         KIND_CJK_32X32:   w = 6'd32;
      endcase
      return w;
   endfunction

   function automatic logic [DIM_W-1:0] kind_height(input kind_type kind);
      logic [DIM_W-1:0] h;
      unique case (kind)
         KIND_ASCII_8X16:  h = 6'd16;
         KIND_ASCII_16X32: h = 6'd32;
         KIND_CJK_16X16:   h = 6'd16;
         KIND_CJK_32X32:   h = 6'd32;
      endcase
      return h;
   endfunction

   // rightmost legal cursor column after an advance
   function automatic logic [LIMIT_W-1:0] wrap_limit(input kind_type kind);
      return LIMIT_W'(SCREEN_SIZE) - {{(LIMIT_W-DIM_W){1'b0}}, kind_width(kind)};
   endfunction

endpackage

@@ rtl/core/grtr_req_if.sv @@
// ----------------------------------------------------------------------------
// grtr_req_if
// Glyph row request channel: valid/ready with one bitmap row and cursor data.
// ----------------------------------------------------------------------------
interface grtr_req_if;
   logic                                 valid;
   logic                                 ready;
   logic                                 start_new;
   logic [grtr_pkg::COORD_W-1:0]         start_row;
   logic [grtr_pkg::COORD_W-1:0]         start_col;
   logic [grtr_pkg::KIND_W-1:0]          glyph_kind;
   logic [grtr_pkg::ROW_BITS_W-1:0]      row_bits;

   modport source (
      output valid, start_new, start_row, start_col, glyph_kind, row_bits,
      input  ready
   );

   modport sink (
      input  valid, start_new, start_row, start_col, glyph_kind, row_bits,
      output ready
   );
endinterface

@@ rtl/core/grtr_rsp_if.sv @@
// ----------------------------------------------------------------------------
// grtr_rsp_if
// Pixel write channel: valid/ready with screen position and color.
// ----------------------------------------------------------------------------
interface grtr_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [grtr_pkg::COORD_W-1:0]      pixel_row;
   logic [grtr_pkg::COORD_W-1:0]      pixel_col;
   logic [grtr_pkg::COLOR_W-1:0]      pixel_color;
   logic                              last;

   modport source (
      output valid, pixel_row, pixel_col, pixel_color, last,
      input  ready
   );

   modport sink (
      input  valid, pixel_row, pixel_col, pixel_color, last,
      output ready
   );
endinterface

@@ rtl/core/grtr_row_serializer.sv @@
// ----------------------------------------------------------------------------
// grtr_row_serializer
// Left-aligns a glyph row and shifts it out one pixel bit per step.
// ----------------------------------------------------------------------------
module grtr_row_serializer (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               load,
   input  logic                               step,
   input  logic [grtr_pkg::ROW_BITS_W-1:0]    row_bits,
   input  grtr_pkg::kind_type                 kind,
   input  logic                               opaque,
   output grtr_pkg::ser_status_type           status
);

   logic [grtr_pkg::ROW_BITS_W-1:0] shift_ff, shift_in;
   logic [grtr_pkg::CNT_W-1:0]      cnt_ff, cnt_in;
   logic [grtr_pkg::CNT_W-1:0]      wmax_ff, wmax_in;
   logic [grtr_pkg::ROW_BITS_W-1:0] aligned;

   // drop bits above the glyph width by pushing the row to the top
   always_comb begin
      unique case (kind)
         grtr_pkg::KIND_ASCII_8X16:  aligned = {row_bits[7:0], 24'd0};
         grtr_pkg::KIND_ASCII_16X32: aligned = {row_bits[15:0], 16'd0};
         grtr_pkg::KIND_CJK_16X16:   aligned = {row_bits[15:0], 16'd0};
         grtr_pkg::KIND_CJK_32X32:   aligned = row_bits;
      endcase
   end

   always_comb begin
      shift_in = shift_ff;
      cnt_in   = cnt_ff;
      wmax_in  = wmax_ff;
      if (load) begin
         shift_in = aligned;
         cnt_in   = '0;
         wmax_in  = grtr_pkg::CNT_W'(grtr_pkg::kind_width(kind) - 6'd1);
      end else if (step) begin
         shift_in = {shift_ff[grtr_pkg::ROW_BITS_W-2:0], 1'b0};
         cnt_in   = cnt_ff + 5'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         wmax_ff <= '0;
      end else begin
         cnt_ff  <= cnt_in;
         wmax_ff <= wmax_in;
      end
      shift_ff <= shift_in;
   end

   // transparent rows end at the last set bit, opaque rows at the glyph width
   always_comb begin
      status.pix_set  = shift_ff[grtr_pkg::ROW_BITS_W-1];
      status.pix_emit = shift_ff[grtr_pkg::ROW_BITS_W-1] | opaque;
      status.row_done = opaque ? (cnt_ff == wmax_ff)
                               : (shift_ff[grtr_pkg::ROW_BITS_W-2:0] == '0);
   end

endmodule

@@ rtl/core/glyph_row_text_renderer.sv @@
// ----------------------------------------------------------------------------
// glyph_row_text_renderer
// A taken row request loads the serializer; each emitted pixel then passes the
//   output register, and transparent mode writes no pixel for a clear bit.
// No new request is taken until the row's last pixel (width 8, 16 or 32) steps
//   out; output stalls freeze the shifter, transparent rows stop early.
// Reset (synchronous): cursor and glyph row go to 0, colors FFFF/0000, opaque on.
// ----------------------------------------------------------------------------
`include "glyph_row_text_renderer_macros.svh"

module glyph_row_text_renderer (
   input  logic                               clock,
   input  logic                               reset,
   grtr_req_if.sink                           req_ch,
   grtr_rsp_if.source                         rsp_ch,
   input  logic                               csr_we,
   input  logic [grtr_pkg::CSR_IDX_W-1:0]     csr_idx,
   input  logic [grtr_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   grtr_pkg::state_type              state_ff, state_in;
   logic [grtr_pkg::COORD_W-1:0]     cur_row_ff, cur_row_in;
   logic [grtr_pkg::COORD_W-1:0]     cur_col_ff, cur_col_in;
   logic [grtr_pkg::RIG_W-1:0]       rig_ff, rig_in;
   logic [grtr_pkg::COLOR_W-1:0]     font_ff, font_in;
   logic [grtr_pkg::COLOR_W-1:0]     back_ff, back_in;
   logic                             opaque_ff, opaque_in;
   logic [grtr_pkg::COORD_W-1:0]     pix_row_ff, pix_row_in;
   logic [grtr_pkg::COORD_W-1:0]     pix_col_ff, pix_col_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   logic [grtr_pkg::COORD_W-1:0]     rsp_row_ff, rsp_row_in;
   logic [grtr_pkg::COORD_W-1:0]     rsp_col_ff, rsp_col_in;
   logic [grtr_pkg::COLOR_W-1:0]     rsp_color_ff, rsp_color_in;
   logic                             rsp_last_ff, rsp_last_in;

   logic                             req_accept;
   logic                             step;
   logic                             row_finish;
   logic                             rsp_stall;
   grtr_pkg::kind_type               kind;
   logic [grtr_pkg::DIM_W-1:0]       width;
   logic [grtr_pkg::DIM_W-1:0]       height;
   logic [grtr_pkg::COORD_W-1:0]     eff_row, eff_col;
   logic [grtr_pkg::RIG_W-1:0]       eff_rig;
   logic                             glyph_end;
   logic [grtr_pkg::LIMIT_W-1:0]     adv_col;
   logic                             wrap;
   grtr_pkg::ser_status_type         ser_status;

   assign req_accept = req_ch.valid & req_ch.ready;
   assign kind       = grtr_pkg::kind_type'(req_ch.glyph_kind);
   assign width      = grtr_pkg::kind_width(kind);
   assign height     = grtr_pkg::kind_height(kind);
   assign row_finish = step & ser_status.row_done;
   assign rsp_stall  = rsp_valid_ff & ~rsp_ch.ready;

   // ---------------- state machine ----------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         grtr_pkg::ST_IDLE: if (req_accept) state_in = grtr_pkg::ST_EMIT;
         grtr_pkg::ST_EMIT: if (step && ser_status.row_done) state_in = grtr_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_ch.ready = (state_ff == grtr_pkg::ST_IDLE);
      step         = (state_ff == grtr_pkg::ST_EMIT) && (!rsp_valid_ff || rsp_ch.ready);
   end

   // ---------------- configuration ----------------
   always_comb begin
      font_in   = font_ff;
      back_in   = back_ff;
      opaque_in = opaque_ff;
      if (csr_we) begin
         unique case (csr_idx)
            grtr_pkg::CSR_FONT_COLOR: font_in   = csr_wdata;
            grtr_pkg::CSR_BACK_COLOR: back_in   = csr_wdata;
            grtr_pkg::CSR_OPAQUE:     opaque_in = csr_wdata[0];
            default: ;
         endcase
      end
   end

   // ---------------- cursor ----------------
   always_comb begin
      eff_row   = req_ch.start_new ? req_ch.start_row : cur_row_ff;
      eff_col   = req_ch.start_new ? req_ch.start_col : cur_col_ff;
      eff_rig   = req_ch.start_new ? '0 : rig_ff;
      glyph_end = ({1'b0, eff_rig} + 6'd1) >= height;
      adv_col   = {1'b0, eff_col} + {4'd0, width};
      wrap      = adv_col > grtr_pkg::wrap_limit(kind);

      cur_row_in = cur_row_ff;
      cur_col_in = cur_col_ff;
      rig_in     = rig_ff;
      pix_row_in = pix_row_ff;
      pix_col_in = pix_col_ff;
      if (req_accept) begin
         pix_row_in = eff_row + {4'd0, eff_rig};
         pix_col_in = eff_col;
         cur_row_in = eff_row;
         cur_col_in = eff_col;
         rig_in     = eff_rig + 5'd1;
         if (glyph_end) begin
            rig_in = '0;
            if (wrap) begin
               cur_col_in = '0;
               cur_row_in = eff_row + {3'd0, height};
            end else begin
               cur_col_in = adv_col[grtr_pkg::COORD_W-1:0];
            end
         end
      end else if (step) begin
         pix_col_in = pix_col_ff + 9'd1;
      end
   end

   // ---------------- output register ----------------
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_row_in   = rsp_row_ff;
      rsp_col_in   = rsp_col_ff;
      rsp_color_in = rsp_color_ff;
      rsp_last_in  = rsp_last_ff;
      if (step) begin
         rsp_valid_in = ser_status.pix_emit;
         if (ser_status.pix_emit) begin
            rsp_row_in   = pix_row_ff;
            rsp_col_in   = pix_col_ff;
            rsp_color_in = ser_status.pix_set ? font_ff : back_ff;
            rsp_last_in  = ser_status.row_done;
         end
      end
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.pixel_row   = rsp_row_ff;
   assign rsp_ch.pixel_col   = rsp_col_ff;
   assign rsp_ch.pixel_color = rsp_color_ff;
   assign rsp_ch.last        = rsp_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= grtr_pkg::ST_IDLE;
         cur_row_ff   <= '0;
         cur_col_ff   <= '0;
         rig_ff       <= '0;
         font_ff      <= grtr_pkg::FONT_COLOR_RST;
         back_ff      <= grtr_pkg::BACK_COLOR_RST;
         opaque_ff    <= grtr_pkg::OPAQUE_RST;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cur_row_ff   <= cur_row_in;
         cur_col_ff   <= cur_col_in;
         rig_ff       <= rig_in;
         font_ff      <= font_in;
         back_ff      <= back_in;
         opaque_ff    <= opaque_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pix_row_ff   <= pix_row_in;
      pix_col_ff   <= pix_col_in;
      rsp_row_ff   <= rsp_row_in;
      rsp_col_ff   <= rsp_col_in;
      rsp_color_ff <= rsp_color_in;
      rsp_last_ff  <= rsp_last_in;
   end

   grtr_row_serializer u_serializer (
      .clock    (clock),
      .reset    (reset),
      .load     (req_accept),
      .step     (step),
      .row_bits (req_ch.row_bits),
      .kind     (kind),
      .opaque   (opaque_ff),
      .status   (ser_status)
   );

   // ---------------- assertions ----------------
   `GRTR_ASSERT_NEXT(a_accept_starts_emit, req_accept, state_ff == grtr_pkg::ST_EMIT)
   `GRTR_ASSERT_NEXT(a_row_done_ends_emit, row_finish, state_ff == grtr_pkg::ST_IDLE)
   `GRTR_ASSERT_NEXT(a_stall_holds_column, state_ff == grtr_pkg::ST_EMIT && rsp_stall, $stable(pix_col_ff))

endmodule
